@@ hdl/wcf_pkg.sv @@
package wcf_pkg;

    localparam int unsigned WORD_W    = 16;
    localparam int unsigned QUO_W     = 17;
    localparam int unsigned NORM_BITS = 30;

    localparam logic [QUO_W-1:0] QUO_MAX_POS = 17'd32767;
    localparam logic [QUO_W-1:0] QUO_MAX_NEG = 17'd32768;

    typedef struct packed {
        logic signed [WORD_W-1:0] axis_x;
        logic signed [WORD_W-1:0] axis_y;
        logic signed [WORD_W-1:0] axis_z;
    } t_axis_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] tangent_x;
        logic signed [WORD_W-1:0] tangent_y;
        logic signed [WORD_W-1:0] tangent_z;
        logic signed [WORD_W-1:0] lateral_x;
        logic signed [WORD_W-1:0] lateral_y;
        logic signed [WORD_W-1:0] lateral_z;
        logic signed [WORD_W-1:0] normal_x;
        logic signed [WORD_W-1:0] normal_y;
        logic signed [WORD_W-1:0] normal_z;
        logic                     degenerate;
    } t_frame_out;

endpackage

@@ hdl/wcf_isqrt.sv @@
module wcf_isqrt #(
    parameter int VW = 62,
    parameter int PW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [VW-1:0]     i_val,
    input  logic [PW-1:0]     i_pay,
    output logic              o_vld,
    output logic [VW/2-1:0]   o_root,
    output logic [PW-1:0]     o_pay
);
    localparam int RW   = VW / 2;
    localparam int REMW = RW + 3;

    logic [REMW-1:0] r_rem  [1:RW];
    logic [RW-1:0]   r_root [1:RW];
    logic [VW-1:0]   r_val  [1:RW];
    logic [PW-1:0]   r_pay  [1:RW];
    logic            r_vld  [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [REMW-1:0] p_rem, n_rem, w_sh, w_try;
        logic [RW-1:0]   p_root, n_root;
        logic [VW-1:0]   p_val;
        logic [PW-1:0]   p_pay;
        logic            p_vld;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_val  = i_val;
            assign p_pay  = i_pay;
            assign p_vld  = i_vld;
        end else begin : g_next
            assign p_rem  = r_rem[k];
            assign p_root = r_root[k];
            assign p_val  = r_val[k];
            assign p_pay  = r_pay[k];
            assign p_vld  = r_vld[k];
        end

        always_comb begin
            w_sh  = {p_rem[REMW-3:0], p_val[VW-1 -: 2]};
            w_try = {{(REMW-RW-2){1'b0}}, p_root, 2'b01};
            if (w_sh >= w_try) begin
                n_rem  = w_sh - w_try;
                n_root = {p_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_root = {p_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= p_vld;
            end
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
                r_val[k+1]  <= {p_val[VW-3:0], 2'b00};
                r_pay[k+1]  <= p_pay;
            end
        end
    end

    assign o_vld  = r_vld[RW];
    assign o_root = r_root[RW];
    assign o_pay  = r_pay[RW];

endmodule

@@ hdl/wcf_div3.sv @@
module wcf_div3 #(
    parameter int NW  = 45,
    parameter int DVW = 31,
    parameter int PW  = 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic [2:0][NW-1:0]                     i_num,
    input  logic [DVW-1:0]                         i_den,
    input  logic [PW-1:0]                          i_pay,
    output logic                                   o_vld,
    output logic [2:0][wcf_pkg::QUO_W-1:0]         o_quo,
    output logic [2:0]                             o_ovf,
    output logic [PW-1:0]                          o_pay
);
    import wcf_pkg::*;

    localparam int QB = QUO_W;
    localparam int CW = ((NW > DVW + QB) ? NW : DVW + QB) + 1;

    logic [2:0][NW-1:0] r_rem [1:QB];
    logic [2:0][QB-1:0] r_quo [1:QB];
    logic [2:0]         r_ovf [1:QB];
    logic [DVW-1:0]     r_den [1:QB];
    logic [PW-1:0]      r_pay [1:QB];
    logic               r_vld [1:QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int B = QB - 1 - k;
        logic [2:0][NW-1:0] p_rem, n_rem;
        logic [2:0][QB-1:0] p_quo, n_quo;
        logic [2:0]         p_ovf, n_ovf;
        logic [DVW-1:0]     p_den;
        logic [PW-1:0]      p_pay;
        logic               p_vld;
        logic [CW-1:0]      w_dsh, w_dtop;

        if (k == 0) begin : g_first
            assign p_rem = i_num;
            assign p_quo = '0;
            assign p_ovf = '0;
            assign p_den = i_den;
            assign p_pay = i_pay;
            assign p_vld = i_vld;
        end else begin : g_next
            assign p_rem = r_rem[k];
            assign p_quo = r_quo[k];
            assign p_ovf = r_ovf[k];
            assign p_den = r_den[k];
            assign p_pay = r_pay[k];
            assign p_vld = r_vld[k];
        end

        always_comb begin
            w_dsh  = {{(CW-DVW){1'b0}}, p_den} << B;
            w_dtop = {{(CW-DVW){1'b0}}, p_den} << QB;
            n_rem  = p_rem;
            n_quo  = p_quo;
            n_ovf  = p_ovf;
            for (int j = 0; j < 3; j++) begin
                if (k == 0) begin
                    n_ovf[j] = ({{(CW-NW){1'b0}}, p_rem[j]} >= w_dtop);
                end
                if ({{(CW-NW){1'b0}}, p_rem[j]} >= w_dsh) begin
                    n_rem[j]    = p_rem[j] - w_dsh[NW-1:0];
                    n_quo[j][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= p_vld;
            end
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_quo[k+1] <= n_quo;
                r_ovf[k+1] <= n_ovf;
                r_den[k+1] <= p_den;
                r_pay[k+1] <= p_pay;
            end
        end
    end

    assign o_vld = r_vld[QB];
    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];
    assign o_pay = r_pay[QB];

endmodule

@@ hdl/wcf_unit.sv @@
module wcf_unit #(
    parameter int FRAC_BITS = 14,
    parameter int MW        = 32,
    parameter int TW        = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [2:0][MW-1:0]                i_mag,
    input  logic [2:0]                        i_neg,
    input  logic [TW-1:0]                     i_tag,
    output logic                              o_vld,
    output logic [2:0][wcf_pkg::WORD_W-1:0]   o_val,
    output logic [TW-1:0]                     o_tag
);
    import wcf_pkg::*;

    localparam int NB   = NORM_BITS;
    localparam int SHW  = $clog2(MW + 1);
    localparam int SUMW = 2 * NB + 2;
    localparam int RW   = SUMW / 2;
    localparam int NW   = NB + 1 + FRAC_BITS;
    localparam int PW   = 3 * NB + 3 + TW;
    localparam int DPW  = 3 + TW;

    logic [2:0][MW-1:0]     r1_mag, r2_mag;
    logic [2:0][NB-1:0]     r3_mag, r4_mag, r5_mag;
    logic [2:0][2*NB-1:0]   r4_sq;
    logic [SUMW-1:0]        r5_sum;
    logic [SHW-1:0]         r2_sh, n_sh;
    logic [2:0]             r1_neg, r2_neg, r3_neg, r4_neg, r5_neg, r6_neg;
    logic [TW-1:0]          r1_tag, r2_tag, r3_tag, r4_tag, r5_tag, r6_tag, r7_tag;
    logic                   r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    logic [2:0][NW-1:0]     r6_num, n_num;
    logic [RW-1:0]          r6_den, n_den;
    logic [2:0][WORD_W-1:0] r7_val, n_val;

    logic [MW-1:0]          w_or;
    logic [SHW-1:0]         w_bl;
    logic [2:0][MW-1:0]     w_shf;

    logic                   s_vld;
    logic [RW-1:0]          s_root;
    logic [PW-1:0]          s_pay;
    logic [2:0][NB-1:0]     s_mag;
    logic [2:0]             s_neg;
    logic [TW-1:0]          s_tag;

    logic                   d_vld;
    logic [2:0][QUO_W-1:0]  d_quo;
    logic [2:0]             d_ovf;
    logic [DPW-1:0]         d_pay;
    logic [2:0]             d_neg;
    logic [TW-1:0]          d_tag;
    logic [QUO_W-1:0]       w_negq;

    // leading one of the largest magnitude sets the common right shift
    always_comb begin
        w_or = r1_mag[0] | r1_mag[1] | r1_mag[2];
        w_bl = '0;
        for (int i = 0; i < MW; i++) begin
            if (w_or[i]) begin
                w_bl = SHW'(i + 1);
            end
        end
        n_sh = (w_bl > SHW'(NB)) ? (w_bl - SHW'(NB)) : '0;
        for (int j = 0; j < 3; j++) begin
            w_shf[j] = r2_mag[j] >> r2_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
        if (i_en) begin
            r1_mag <= i_mag;
            r1_neg <= i_neg;
            r1_tag <= i_tag;
            r2_mag <= r1_mag;
            r2_sh  <= n_sh;
            r2_neg <= r1_neg;
            r2_tag <= r1_tag;
            for (int j = 0; j < 3; j++) begin
                r3_mag[j] <= w_shf[j][NB-1:0];
                r4_sq[j]  <= (2*NB)'(r3_mag[j]) * (2*NB)'(r3_mag[j]);
            end
            r3_neg <= r2_neg;
            r3_tag <= r2_tag;
            r4_mag <= r3_mag;
            r4_neg <= r3_neg;
            r4_tag <= r3_tag;
            r5_sum <= {2'b00, r4_sq[0]} + {2'b00, r4_sq[1]} + {2'b00, r4_sq[2]};
            r5_mag <= r4_mag;
            r5_neg <= r4_neg;
            r5_tag <= r4_tag;
        end
    end

    wcf_isqrt #(
        .VW (SUMW),
        .PW (PW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r5_vld),
        .i_val   (r5_sum),
        .i_pay   ({r5_mag, r5_neg, r5_tag}),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_pay   (s_pay)
    );

    assign {s_mag, s_neg, s_tag} = s_pay;

    // numerator rounds half up on the magnitude
    always_comb begin
        n_den = (s_root == '0) ? RW'(1) : s_root;
        for (int j = 0; j < 3; j++) begin
            n_num[j] = {1'b0, s_mag[j], {FRAC_BITS{1'b0}}}
                     + {{(NW-RW+1){1'b0}}, n_den[RW-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld <= s_vld;
        end
        if (i_en) begin
            r6_num <= n_num;
            r6_den <= n_den;
            r6_neg <= s_neg;
            r6_tag <= s_tag;
        end
    end

    wcf_div3 #(
        .NW  (NW),
        .DVW (RW),
        .PW  (DPW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r6_vld),
        .i_num   (r6_num),
        .i_den   (r6_den),
        .i_pay   ({r6_neg, r6_tag}),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_ovf   (d_ovf),
        .o_pay   (d_pay)
    );

    assign {d_neg, d_tag} = d_pay;

    // saturate to the signed word range
    always_comb begin
        w_negq = '0;
        for (int j = 0; j < 3; j++) begin
            if (d_neg[j]) begin
                if (d_ovf[j] || d_quo[j] > QUO_MAX_NEG) begin
                    w_negq = QUO_W'(0) - QUO_MAX_NEG;
                end else begin
                    w_negq = QUO_W'(0) - d_quo[j];
                end
                n_val[j] = w_negq[WORD_W-1:0];
            end else begin
                if (d_ovf[j] || d_quo[j] > QUO_MAX_POS) begin
                    n_val[j] = QUO_MAX_POS[WORD_W-1:0];
                end else begin
                    n_val[j] = d_quo[j][WORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r7_vld <= d_vld;
        end
        if (i_en) begin
            r7_val <= n_val;
            r7_tag <= d_tag;
        end
    end

    assign o_vld = r7_vld;
    assign o_val = r7_val;
    assign o_tag = r7_tag;

endmodule

@@ hdl/wheel_contact_frame_core.sv @@
// wheel contact frame core
// input channel: i_valid / o_ready carry one wheel axis (Q2.14 by default,
// FRAC_BITS fraction bits) per transaction on i_axis
// output channel: o_valid / i_ready carry one contact frame per transaction
// on o_frame: unit tangent, the axis passed through as lateral, unit normal
// and a degenerate flag, set with all vectors zero when the axis is vertical
// pipeline: 57 register stages, set by the bit-per-stage square root
// (31 stages) and the bit-per-stage divider (17 stages) plus nine stages
// of products, shift, squares, sums, numerator and saturation
// throughput: one transaction per cycle when no stall holds the pipeline;
// every stage is a plain register
// reset: synchronous, active low, clears every stage valid; nothing is kept
// stall: while o_valid is high and i_ready is low the whole pipeline holds,
// o_ready drops and the waiting frame stays on o_frame
module wheel_contact_frame_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  wcf_pkg::t_axis_in    i_axis,
    output logic                 o_valid,
    input  logic                 i_ready,
    output wcf_pkg::t_frame_out  o_frame
);
    import wcf_pkg::*;

    localparam int MW  = ((2 * FRAC_BITS > NORM_BITS) ? 2 * FRAC_BITS : NORM_BITS) + 2;
    localparam int NTW = 3 * WORD_W + 1;

    logic                     w_en;
    t_axis_in                 r1_axis, r2_axis;
    logic                     r1_vld, r2_vld, r2_deg;
    logic signed [2*WORD_W-1:0] r2_pxz, r2_pyz, r2_pzz;

    logic signed [MW:0]       w_one, w_n2;
    logic [2*WORD_W-1:0]      w_axz, w_ayz;
    logic [WORD_W:0]          w_ax, w_ay;
    logic [2:0][MW-1:0]       w_nmag, w_tmag;
    logic [2:0]               w_nneg, w_tneg;

    logic                     n_vld, t_vld;
    logic [2:0][WORD_W-1:0]   n_val, t_val;
    logic [NTW-1:0]           n_tag;
    logic                     t_tag;
    logic                     w_deg;

    assign w_en    = !n_vld || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r1_axis <= i_axis;
            r2_axis <= r1_axis;
            r2_deg  <= (r1_axis.axis_x == '0) && (r1_axis.axis_y == '0);
            r2_pxz  <= (2*WORD_W)'(r1_axis.axis_x) * (2*WORD_W)'(r1_axis.axis_z);
            r2_pyz  <= (2*WORD_W)'(r1_axis.axis_y) * (2*WORD_W)'(r1_axis.axis_z);
            r2_pzz  <= (2*WORD_W)'(r1_axis.axis_z) * (2*WORD_W)'(r1_axis.axis_z);
        end
    end

    // normal = (-sx*sz, -sy*sz, 1 - sz*sz), tangent along (sy, -sx, 0)
    always_comb begin
        w_one = '0;
        w_one[2*FRAC_BITS] = 1'b1;
        w_n2  = w_one - (MW+1)'(r2_pzz);
        w_axz = r2_pxz[2*WORD_W-1] ? -r2_pxz : r2_pxz;
        w_ayz = r2_pyz[2*WORD_W-1] ? -r2_pyz : r2_pyz;
        w_nmag[0] = MW'(w_axz);
        w_nmag[1] = MW'(w_ayz);
        w_nmag[2] = w_n2[MW] ? (w_n2[MW-1:0] ^ {MW{1'b1}}) + MW'(1) : w_n2[MW-1:0];
        w_nneg[0] = (r2_pxz > 0);
        w_nneg[1] = (r2_pyz > 0);
        w_nneg[2] = w_n2[MW];

        w_ay = r2_axis.axis_y[WORD_W-1] ? (WORD_W+1)'(-r2_axis.axis_y)
                                         : (WORD_W+1)'(r2_axis.axis_y);
        w_ax = r2_axis.axis_x[WORD_W-1] ? (WORD_W+1)'(-r2_axis.axis_x)
                                         : (WORD_W+1)'(r2_axis.axis_x);
        if (r2_axis.axis_y[WORD_W-1]) begin
            w_ay = (WORD_W+1)'(0) - {1'b1, r2_axis.axis_y};
        end
        if (r2_axis.axis_x[WORD_W-1]) begin
            w_ax = (WORD_W+1)'(0) - {1'b1, r2_axis.axis_x};
        end
        w_tmag[0] = MW'(w_ay);
        w_tmag[1] = MW'(w_ax);
        w_tmag[2] = '0;
        w_tneg[0] = r2_axis.axis_y[WORD_W-1];
        w_tneg[1] = !r2_axis.axis_x[WORD_W-1] && (r2_axis.axis_x != '0);
        w_tneg[2] = 1'b0;
    end

    wcf_unit #(
        .FRAC_BITS (FRAC_BITS),
        .MW        (MW),
        .TW        (NTW)
    ) u_normal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r2_vld),
        .i_mag   (w_nmag),
        .i_neg   (w_nneg),
        .i_tag   ({r2_deg, r2_axis}),
        .o_vld   (n_vld),
        .o_val   (n_val),
        .o_tag   (n_tag)
    );

    wcf_unit #(
        .FRAC_BITS (FRAC_BITS),
        .MW        (MW),
        .TW        (1)
    ) u_tangent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r2_vld),
        .i_mag   (w_tmag),
        .i_neg   (w_tneg),
        .i_tag   (r2_deg),
        .o_vld   (t_vld),
        .o_val   (t_val),
        .o_tag   (t_tag)
    );

    assign w_deg   = n_tag[NTW-1];
    assign o_valid = n_vld;

    always_comb begin
        o_frame            = '0;
        o_frame.degenerate = w_deg;
        if (!w_deg) begin
            o_frame.tangent_x = t_val[0];
            o_frame.tangent_y = t_val[1];
            o_frame.tangent_z = t_val[2];
            o_frame.lateral_x = n_tag[3*WORD_W-1 -: WORD_W];
            o_frame.lateral_y = n_tag[2*WORD_W-1 -: WORD_W];
            o_frame.lateral_z = n_tag[WORD_W-1:0];
            o_frame.normal_x  = n_val[0];
            o_frame.normal_y  = n_val[1];
            o_frame.normal_z  = n_val[2];
        end
    end

`ifndef SYNTHESIS
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_vld == t_vld)
        else $error("normal and tangent lanes out of step");

    a_flags_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_vld |-> (t_tag == w_deg))
        else $error("degenerate flag differs between lanes");

    a_tangent_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame.tangent_z == '0))
        else $error("tangent has a vertical component");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld && !w_en |=> r2_vld && $stable(r2_axis))
        else $error("front stage moved during a stall");
`endif

endmodule

@@ sim/wheel_contact_frame_core_test.sv @@
`timescale 1ns / 1ps

module wheel_contact_frame_core_test;
    import wcf_pkg::*;

    localparam int FRAC = 14;
    localparam int LATENCY = 57;
    localparam longint CYCLE_LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_axis_in   i_axis = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_frame_out o_frame;

    longint cycles = 0;
    int     degenerate_seen = 0;
    int     frames_seen = 0;
    bit     hold_off = 1'b0;
    bit     stim_done = 1'b0;

    wheel_contact_frame_core #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_axis(i_axis), .o_valid(o_valid), .i_ready(i_ready), .o_frame(o_frame)
    );

    always #2 i_clk = ~i_clk;

    // floor square root, bit by bit
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void to_unit(input longint c[3], output logic signed [15:0] u[3]);
        longint unsigned mag[3];
        longint unsigned mx;
        longint unsigned r;
        longint unsigned q;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? unsigned'(-c[i]) : unsigned'(c[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        r = floor_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        if (r == 0) r = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FRAC) + (r >> 1)) / r;
            if (c[i] < 0) begin
                if (q > 32768) q = 32768;
                u[i] = 16'(-q);
            end else begin
                if (q > 32767) q = 32767;
                u[i] = 16'(q);
            end
        end
    endfunction

    function automatic t_frame_out contact_frame(t_axis_in a);
        t_frame_out f;
        longint sx, sy, sz;
        longint nv[3];
        longint tv[3];
        logic signed [15:0] u[3];
        f = '0;
        sx = longint'(a.axis_x);
        sy = longint'(a.axis_y);
        sz = longint'(a.axis_z);
        if (sx == 0 && sy == 0) begin
            f.degenerate = 1'b1;
            return f;
        end
        nv[0] = -(sx * sz);
        nv[1] = -(sy * sz);
        nv[2] = (64'sd1 <<< (2 * FRAC)) - sz * sz;
        tv[0] = sy;
        tv[1] = -sx;
        tv[2] = 0;
        to_unit(tv, u);
        f.tangent_x = u[0];
        f.tangent_y = u[1];
        f.tangent_z = u[2];
        f.lateral_x = a.axis_x;
        f.lateral_y = a.axis_y;
        f.lateral_z = a.axis_z;
        to_unit(nv, u);
        f.normal_x = u[0];
        f.normal_y = u[1];
        f.normal_z = u[2];
        return f;
    endfunction

    class frame_scoreboard;
        t_frame_out pending[$];
        int errors = 0;

        function void note_axis(t_axis_in a);
            pending.push_back(contact_frame(a));
        endfunction

        function void check_frame(t_frame_out got);
            t_frame_out want;
            if (pending.size() == 0) begin
                $display("%0t unexpected frame %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t frame mismatch: expected %h actual %h", $time, want, got);
                if (got.tangent_x !== want.tangent_x)
                    $display("  tangent_x %0d %0d", want.tangent_x, got.tangent_x);
                if (got.tangent_y !== want.tangent_y)
                    $display("  tangent_y %0d %0d", want.tangent_y, got.tangent_y);
                if (got.tangent_z !== want.tangent_z)
                    $display("  tangent_z %0d %0d", want.tangent_z, got.tangent_z);
                if (got.lateral_x !== want.lateral_x)
                    $display("  lateral_x %0d %0d", want.lateral_x, got.lateral_x);
                if (got.lateral_y !== want.lateral_y)
                    $display("  lateral_y %0d %0d", want.lateral_y, got.lateral_y);
                if (got.lateral_z !== want.lateral_z)
                    $display("  lateral_z %0d %0d", want.lateral_z, got.lateral_z);
                if (got.normal_x !== want.normal_x)
                    $display("  normal_x %0d %0d", want.normal_x, got.normal_x);
                if (got.normal_y !== want.normal_y)
                    $display("  normal_y %0d %0d", want.normal_y, got.normal_y);
                if (got.normal_z !== want.normal_z)
                    $display("  normal_z %0d %0d", want.normal_z, got.normal_z);
                if (got.degenerate !== want.degenerate)
                    $display("  degenerate %0b %0b", want.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    frame_scoreboard board = new();

    // monitors: input transactions and output transactions at the rising edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && o_ready) board.note_axis(i_axis);
        if (i_rst_n && o_valid && i_ready) begin
            board.check_frame(o_frame);
            frames_seen++;
            if (o_frame.degenerate) degenerate_seen++;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int phase;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_off) i_ready <= 1'b0;
            else if ((phase / 300) % 2 == 0) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        @(posedge i_rst_n);
        repeat (200) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic send_axis(t_axis_in a);
        @(negedge i_clk);
        i_axis <= a;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pause_sender(int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_axis <= '0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 33000)) - 16500);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        t_axis_in directed[$];
        t_axis_in a;
        int burst;
        directed = '{
            '{16'sd0, 16'sd0, 16'sd16384}, '{16'sd0, 16'sd0, -16'sd16384},
            '{16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'h7fff},
            '{16'sd0, 16'sd0, 16'h8000}, '{16'sd16384, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd16384, 16'sd0}, '{-16'sd16384, 16'sd0, 16'sd0},
            '{16'h7fff, 16'h7fff, 16'h7fff}, '{16'h8000, 16'h8000, 16'h8000},
            '{16'h8000, 16'h7fff, 16'h8000}, '{16'sd1, 16'sd0, 16'sd16384},
            '{16'sd0, -16'sd1, 16'sd16383}, '{16'sd11585, 16'sd0, 16'sd11585},
            '{16'sd9459, 16'sd9459, 16'sd9459}, '{16'sd1, 16'sd1, 16'sd0},
            '{16'hffff, 16'hffff, 16'hffff}, '{16'sd5000, -16'sd7000, 16'sd100}
        };
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k]) send_axis(directed[k]);
        for (int n = 0; n < 1350;) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++) begin
                a.axis_x = random_word();
                a.axis_y = random_word();
                a.axis_z = random_word();
                if ($urandom_range(0, 15) == 0) begin
                    a.axis_x = 0;
                    a.axis_y = 0;
                end
                send_axis(a);
                n++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
        end
        pause_sender(0);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (board.pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("checked %0d frames, %0d of them degenerate, under bursty input",
                 frames_seen, degenerate_seen);
        $display("and receiver stalls including one long hold-off");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("%0t timeout", $time);
        $display("simulation failed");
        $finish;
    end
endmodule

@@ files.f @@
hdl/wcf_pkg.sv
hdl/wcf_isqrt.sv
hdl/wcf_div3.sv
hdl/wcf_unit.sv
hdl/wheel_contact_frame_core.sv
sim/wheel_contact_frame_core_test.sv
